### rtl/core/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared types and fixed widths of the running mean / rms deviation block.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 16;
  localparam int SUM_W     = 32;
  localparam int SQSUM_W   = 47;
  localparam int SPREAD_W  = 62;
  localparam int DVD_W     = 94;
  localparam int DVS_W     = 48;
  localparam int REM_W     = 49;
  localparam int QUO_W     = 64;
  localparam int Q16_W     = 32;
  localparam int DEV_W     = 31;
  localparam int STEP_W    = 7;

  localparam logic [STEP_W-1:0] MEAN_DIV_STEPS = STEP_W'(47);
  localparam logic [STEP_W-1:0] DEV_DIV_STEPS  = STEP_W'(94);
  localparam logic [STEP_W-1:0] SQRT_STEPS     = STEP_W'(32);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
  } rmsd_in_t;

  typedef struct packed {
    logic        [COUNT_W-1:0]  sample_count;
    logic signed [SAMPLE_W-1:0] sample_echo;
    logic signed [SUM_W-1:0]    running_total;
    logic signed [Q16_W-1:0]    mean_q16;
    logic        [DEV_W-1:0]    rms_deviation_q16;
    logic        [DEV_W-1:0]    mean_sigma_q16;
    logic                       count_overflow;
  } rmsd_out_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ACCUM, OP_MUL1, OP_MUL2, OP_SPREAD,
    OP_DIV_LOAD, OP_DIV_STEP, OP_SQRT_LOAD, OP_SQRT_STEP, OP_SAVE, OP_EMIT
  } rmsd_op_t;

  typedef enum logic [1:0] {
    SEL_MEAN, SEL_RMSD, SEL_SIGMA
  } rmsd_sel_t;

  typedef struct packed {
    rmsd_op_t  op;
    rmsd_sel_t sel;
  } rmsd_cmd_t;

  typedef struct packed {
    logic last;
  } rmsd_stat_t;

endpackage

### rtl/core/rmsd_dp.sv
// ----------------------------------------------------------------------------
// rmsd_dp
// Accumulators, product stage, shared restoring divider and square root.
// ----------------------------------------------------------------------------
module rmsd_dp import rmsd_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  rmsd_cmd_t  cmd,
  input  rmsd_in_t   in_data,
  output rmsd_stat_t stat,
  output rmsd_out_t  result
);

  localparam logic [COUNT_W-1:0] CountMax = COUNT_W'((1 << COUNT_BITS) - 1);

  logic signed [SAMPLE_W-1:0] x_reg;
  logic                       last_reg;
  logic [COUNT_W-1:0]         count_reg;
  logic signed [SUM_W-1:0]    sum_reg;
  logic [SQSUM_W-1:0]         sq_sum_reg;
  logic                       overflow_reg;
  logic [39:0]                prod_lo;
  logic [38:0]                prod_hi;
  logic [SPREAD_W-1:0]        mag_sq;
  logic [31:0]                nn_reg;
  logic [DVS_W-1:0]           nnn_reg;
  logic [SPREAD_W-1:0]        msa_reg;
  logic [SPREAD_W-1:0]        ms_reg;
  logic                       spread_pos;
  logic [REM_W-1:0]           rem;
  logic [DVD_W-1:0]           dvd;
  logic [DVS_W-1:0]           dvs;
  logic [QUO_W-1:0]           quo;
  logic [QUO_W-1:0]           sq_v;
  logic [QUO_W-1:0]           sq_res;
  logic [QUO_W-1:0]           sq_bit;
  logic signed [Q16_W-1:0]    mean_reg;
  logic [DEV_W-1:0]           rmsd_reg;
  logic [DEV_W-1:0]           sigma_reg;

  logic signed [SAMPLE_W-1:0] x_ext;
  logic signed [2*SAMPLE_W-1:0] x_sq;
  logic [SUM_W-1:0]           mag;
  logic [REM_W-1:0]           rem_sh;
  logic                       rem_ge;
  logic [QUO_W-1:0]           sq_trial;
  logic                       dev_ok;

  assign x_ext    = SAMPLE_W'($signed(in_data.sample_value[SAMPLE_BITS-1:0]));
  assign x_sq     = x_reg * x_reg;
  assign mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
  assign rem_sh   = {rem[REM_W-2:0], dvd[DVD_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, dvs};
  assign sq_trial = sq_res + sq_bit;
  assign dev_ok   = spread_pos && (count_reg != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg    <= '0;
      sum_reg      <= '0;
      sq_sum_reg   <= '0;
      overflow_reg <= 1'b0;
      last_reg     <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          x_reg    <= x_ext;
          last_reg <= in_data.last_sample;
        end
        OP_ACCUM: begin
          if (count_reg >= CountMax) begin
            overflow_reg <= 1'b1;
          end else begin
            count_reg  <= count_reg + 1'b1;
            sum_reg    <= sum_reg + SUM_W'(x_reg);
            sq_sum_reg <= sq_sum_reg + SQSUM_W'(x_sq[2*SAMPLE_W-2:0]);
          end
        end
        OP_MUL1: begin
          prod_lo <= 40'(count_reg) * 40'(sq_sum_reg[23:0]);
          prod_hi <= 39'(count_reg) * 39'(sq_sum_reg[SQSUM_W-1:24]);
          mag_sq  <= SPREAD_W'(mag[30:0]) * SPREAD_W'(mag[30:0]);
          nn_reg  <= 32'(count_reg) * 32'(count_reg);
        end
        OP_MUL2: begin
          msa_reg <= SPREAD_W'(prod_lo) + SPREAD_W'({prod_hi, 24'b0});
          nnn_reg <= DVS_W'(nn_reg) * DVS_W'(count_reg);
        end
        OP_SPREAD: begin
          spread_pos <= msa_reg > mag_sq;
          ms_reg     <= msa_reg - mag_sq;
        end
        OP_DIV_LOAD: begin
          rem <= '0;
          quo <= '0;
          case (cmd.sel)
            SEL_MEAN: begin
              dvd <= {mag[30:0], 16'b0, 47'b0};
              dvs <= DVS_W'(count_reg);
            end
            SEL_RMSD: begin
              dvd <= {ms_reg, 32'b0};
              dvs <= DVS_W'(nn_reg);
            end
            default: begin
              dvd <= {ms_reg, 32'b0};
              dvs <= nnn_reg;
            end
          endcase
        end
        OP_DIV_STEP: begin
          rem <= rem_ge ? rem_sh - {1'b0, dvs} : rem_sh;
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          quo <= {quo[QUO_W-2:0], rem_ge};
        end
        OP_SQRT_LOAD: begin
          sq_v   <= quo;
          sq_res <= '0;
          sq_bit <= {2'b01, {(QUO_W-2){1'b0}}};
        end
        OP_SQRT_STEP: begin
          if (sq_v >= sq_trial) begin
            sq_v   <= sq_v - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        OP_SAVE: begin
          case (cmd.sel)
            SEL_MEAN: begin
              if (count_reg == '0) mean_reg <= '0;
              else if (sum_reg[SUM_W-1]) mean_reg <= -$signed(quo[Q16_W-1:0]);
              else mean_reg <= $signed(quo[Q16_W-1:0]);
            end
            SEL_RMSD: rmsd_reg <= dev_ok ? sq_res[DEV_W-1:0] : '0;
            default:  sigma_reg <= dev_ok ? sq_res[DEV_W-1:0] : '0;
          endcase
        end
        OP_EMIT: begin
          if (last_reg) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            overflow_reg <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.last = last_reg;

  assign result.sample_count      = count_reg;
  assign result.sample_echo       = x_reg;
  assign result.running_total     = sum_reg;
  assign result.mean_q16          = mean_reg;
  assign result.rms_deviation_q16 = rmsd_reg;
  assign result.mean_sigma_q16    = sigma_reg;
  assign result.count_overflow    = overflow_reg;

endmodule

### rtl/core/rmsd_ctrl.sv
// ----------------------------------------------------------------------------
// rmsd_ctrl
// Sequencer: accumulate, then on a reporting beat products, a divide for each statistic and a root for both deviations.
// ----------------------------------------------------------------------------
module rmsd_ctrl import rmsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       emit_every_sample,
  input  logic       out_free,
  input  rmsd_stat_t stat,
  output rmsd_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ACCUM, S_MUL1, S_MUL2, S_SPREAD, S_DIV_LD, S_DIV_RUN,
    S_SQ_LD, S_SQ_RUN, S_SAVE, S_EMIT
  } state_t;

  state_t              state;
  rmsd_sel_t           sel;
  logic [STEP_W-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= SEL_MEAN;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE:   if (in_valid) state <= S_ACCUM;
        S_ACCUM: begin
          sel   <= SEL_MEAN;
          state <= (emit_every_sample || stat.last) ? S_MUL1 : S_IDLE;
        end
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_SPREAD;
        S_SPREAD: state <= S_DIV_LD;
        S_DIV_LD: begin
          cnt   <= (sel == SEL_MEAN) ? MEAN_DIV_STEPS - 1'b1 : DEV_DIV_STEPS - 1'b1;
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (cnt == '0) state <= (sel == SEL_MEAN) ? S_SAVE : S_SQ_LD;
          else cnt <= cnt - 1'b1;
        end
        S_SQ_LD: begin
          cnt   <= SQRT_STEPS - 1'b1;
          state <= S_SQ_RUN;
        end
        S_SQ_RUN: begin
          if (cnt == '0) state <= S_SAVE;
          else cnt <= cnt - 1'b1;
        end
        S_SAVE: begin
          case (sel)
            SEL_MEAN: begin
              sel   <= SEL_RMSD;
              state <= S_DIV_LD;
            end
            SEL_RMSD: begin
              sel   <= SEL_SIGMA;
              state <= S_DIV_LD;
            end
            default:  state <= S_EMIT;
          endcase
        end
        S_EMIT:   if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cmd.sel  = sel;

  always_comb begin
    case (state)
      S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_ACCUM:   cmd.op = OP_ACCUM;
      S_MUL1:    cmd.op = OP_MUL1;
      S_MUL2:    cmd.op = OP_MUL2;
      S_SPREAD:  cmd.op = OP_SPREAD;
      S_DIV_LD:  cmd.op = OP_DIV_LOAD;
      S_DIV_RUN: cmd.op = OP_DIV_STEP;
      S_SQ_LD:   cmd.op = OP_SQRT_LOAD;
      S_SQ_RUN:  cmd.op = OP_SQRT_STEP;
      S_SAVE:    cmd.op = OP_SAVE;
      S_EMIT:    cmd.op = out_free ? OP_EMIT : OP_NONE;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/core/running_mean_rmsd_accumulator.sv
// ----------------------------------------------------------------------------
// running_mean_rmsd_accumulator
// Running count, sum, mean, rms deviation and sigma of the mean over samples.
// ----------------------------------------------------------------------------
// sequence: a beat is loaded and accumulated; a reporting beat then runs the
//   product and spread steps, the divider for the mean, and divider and square
//   root for rms deviation and sigma of the mean, with load and save steps
// throughput: set by the one-bit-per-cycle shared divider and root loop; a
//   new beat is accepted only when the sequencer is idle again
// reset: synchronous rst clears accumulators, mode register and output valid
module running_mean_rmsd_accumulator import rmsd_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  rmsd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rmsd_out_t out_data
);

  // mode register: report after every beat, or only on the last one
  logic       emit_every_sample;
  logic       out_free;
  rmsd_cmd_t  ctrl_cmd;
  rmsd_stat_t dp_stat;
  rmsd_out_t  dp_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_every_sample <= 1'b0;
    end else if (cfg_wr_en) begin
      emit_every_sample <= cfg_wr_data;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  rmsd_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .emit_every_sample (emit_every_sample),
    .out_free          (out_free),
    .stat              (dp_stat),
    .cmd               (ctrl_cmd)
  );

  rmsd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ctrl_cmd),
    .in_data (in_data),
    .stat    (dp_stat),
    .result  (dp_result)
  );

  // output register: captures the finished statistics, so the next beat
  // can be taken while this one waits for the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.op == OP_EMIT) begin
      out_data <= dp_result;
    end
  end

  // a result is only loaded when the output slot can take it
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.op == OP_EMIT |-> out_free)
    else $error("result loaded over an untaken result");

  // one beat at a time through the sequencer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  // output valid only rises from an emit command
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl_cmd.op == OP_EMIT))
    else $error("output valid without a result");

endmodule
